[rtl/core/evm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_pkg
// Types, constants and helper functions shared by the view matrix core.
// ----------------------------------------------------------------------------
package evm_pkg;

    localparam int STEPS = 16;
    localparam logic signed [17:0] TURN_Q7 = 18'sd46080;
    localparam logic signed [17:0] HALF_TURN_Q7 = 18'sd23040;
    localparam logic signed [17:0] QUARTER_TURN_Q7 = 18'sd11520;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

    // Rotation state of one CORDIC lane.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [25:0] z;
        logic               flip;
    } t_lane;

    // Angle constants in degrees with 16 fraction bits.
    function automatic logic signed [25:0] atan_q16(input logic [3:0] i);
        unique case (i)
            4'd0:  atan_q16 = 26'sd2949120;
            4'd1:  atan_q16 = 26'sd1740967;
            4'd2:  atan_q16 = 26'sd919879;
            4'd3:  atan_q16 = 26'sd466945;
            4'd4:  atan_q16 = 26'sd234379;
            4'd5:  atan_q16 = 26'sd117304;
            4'd6:  atan_q16 = 26'sd58666;
            4'd7:  atan_q16 = 26'sd29335;
            4'd8:  atan_q16 = 26'sd14668;
            4'd9:  atan_q16 = 26'sd7334;
            4'd10: atan_q16 = 26'sd3667;
            4'd11: atan_q16 = 26'sd1833;
            4'd12: atan_q16 = 26'sd917;
            4'd13: atan_q16 = 26'sd458;
            4'd14: atan_q16 = 26'sd229;
            default: atan_q16 = 26'sd115;
        endcase
    endfunction

    // Clamp a value to the closed unit range in Q1.14.
    function automatic logic signed [16:0] clamp_unit(input logic signed [47:0] v);
        if (v > 48'sd16384) clamp_unit = ONE_Q14;
        else if (v < -48'sd16384) clamp_unit = -ONE_Q14;
        else clamp_unit = v[16:0];
    endfunction

    // Round half up from 14 fraction bits.
    function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
        rnd14 = (v + 48'sd8192) >>> 14;
    endfunction

    // Q1.14 product rounded back to Q1.14.
    function automatic logic signed [17:0] mul14(input logic signed [17:0] a,
                                                 input logic signed [17:0] b);
        logic signed [47:0] p;
        p = 48'(a) * 48'(b);
        mul14 = 18'(rnd14(p));
    endfunction

endpackage

[rtl/core/evm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_in_if / evm_out_if
// Valid/ready channels for camera poses and view matrix rows.
// ----------------------------------------------------------------------------
interface evm_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pitch_deg;
    logic signed [16:0] yaw_deg;
    logic signed [16:0] roll_deg;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, pitch_deg, yaw_deg, roll_deg, pos_x, pos_y, pos_z,
                    input ready);
    modport sink (input valid, pitch_deg, yaw_deg, roll_deg, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface evm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_x, right_y, right_z;
    logic signed [31:0] right_offset;
    logic signed [15:0] up_x, up_y, up_z;
    logic signed [31:0] up_offset;
    logic signed [15:0] back_x, back_y, back_z;
    logic signed [31:0] back_offset;
    modport source (output valid, right_x, right_y, right_z, right_offset,
                    up_x, up_y, up_z, up_offset, back_x, back_y, back_z, back_offset,
                    input ready);
    modport sink (input valid, right_x, right_y, right_z, right_offset,
                  up_x, up_y, up_z, up_offset, back_x, back_y, back_z, back_offset,
                  output ready);
endinterface

[rtl/core/evm_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_cordic_cell
// One CORDIC rotation step for three angle lanes, registered.
// ----------------------------------------------------------------------------
module evm_cordic_cell #(
    parameter logic [3:0] STEP = 4'd0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  evm_pkg::t_lane [2:0] i_lane,
    output evm_pkg::t_lane [2:0] o_lane
);

    evm_pkg::t_lane [2:0] r_lane;
    evm_pkg::t_lane [2:0] n_lane;

    // Rotate toward zero residual angle; arithmetic shift is a floor.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k] = i_lane[k];
            if (i_lane[k].z >= 0) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z - evm_pkg::atan_q16(STEP);
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z + evm_pkg::atan_q16(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

[rtl/core/euler_view_matrix_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_view_matrix_core
// View matrix rows from camera Euler angles and position.
// ----------------------------------------------------------------------------
// The core accepts one pose per cycle unless a stalled sink holds it. The
// pipeline is one angle reduction stage, a chain of sixteen CORDIC cells
// shared by the three angles, and seven matrix stages with at most one
// multiply level each. The whole chain advances when the output register is
// empty or being read, so a stalled sink holds the pipeline in place.
module euler_view_matrix_core (
    input  logic i_clk,
    input  logic i_rst_n,
    evm_in_if.sink    i_pose,
    evm_out_if.source o_mat
);

    localparam int DEPTH = 24;

    logic            w_en;
    logic [DEPTH-1:0] r_vld;

    assign w_en = !r_vld[DEPTH-1] || o_mat.ready;
    assign i_pose.ready = w_en;
    assign o_mat.valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], i_pose.valid};
    end

    // Position travels alongside the CORDIC chain up to the dot product stage.
    logic signed [31:0] r_px [DEPTH-3:0];
    logic signed [31:0] r_py [DEPTH-3:0];
    logic signed [31:0] r_pz [DEPTH-3:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px[0] <= i_pose.pos_x;
            r_py[0] <= i_pose.pos_y;
            r_pz[0] <= i_pose.pos_z;
            for (int k = 1; k <= DEPTH-3; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_pz[k] <= r_pz[k-1];
            end
        end
    end

    // Angle reduction into [-90, 90] degrees with a cosine flip flag.
    function automatic evm_pkg::t_lane reduce(input logic signed [17:0] a);
        evm_pkg::t_lane l;
        logic signed [17:0] r;
        r = a;
        if (r >= evm_pkg::HALF_TURN_Q7) r = r - evm_pkg::TURN_Q7;
        else if (r < -evm_pkg::HALF_TURN_Q7) r = r + evm_pkg::TURN_Q7;
        l.flip = 1'b0;
        if (r > evm_pkg::QUARTER_TURN_Q7) begin
            r = evm_pkg::HALF_TURN_Q7 - r;
            l.flip = 1'b1;
        end else if (r < -evm_pkg::QUARTER_TURN_Q7) begin
            r = -evm_pkg::HALF_TURN_Q7 - r;
            l.flip = 1'b1;
        end
        l.x = evm_pkg::CORDIC_GAIN_Q30;
        l.y = '0;
        l.z = 26'(r) <<< 9;
        return l;
    endfunction

    evm_pkg::t_lane [2:0] r_red;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_red[0] <= reduce(18'(i_pose.pitch_deg));
            r_red[1] <= reduce(-18'(i_pose.yaw_deg));
            r_red[2] <= reduce(18'(i_pose.roll_deg));
        end
    end

    // Chain of CORDIC cells.
    evm_pkg::t_lane [2:0] w_chain [evm_pkg::STEPS:0];
    assign w_chain[0] = r_red;
    for (genvar g = 0; g < evm_pkg::STEPS; g++) begin : g_cell
        evm_cordic_cell #(.STEP(4'(g))) u_cell (
            .i_clk(i_clk), .i_en(w_en), .i_lane(w_chain[g]), .o_lane(w_chain[g+1])
        );
    end

    // Sine and cosine rounding, stage 17.
    function automatic logic signed [17:0] rnd16(input logic signed [33:0] v);
        logic signed [47:0] t;
        t = (48'(v) + 48'sd32768) >>> 16;
        return 18'(evm_pkg::clamp_unit(t));
    endfunction

    logic signed [17:0] r_s [2:0];
    logic signed [17:0] r_c [2:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= rnd16(w_chain[evm_pkg::STEPS][k].y);
                r_c[k] <= w_chain[evm_pkg::STEPS][k].flip ?
                          -rnd16(w_chain[evm_pkg::STEPS][k].x) :
                           rnd16(w_chain[evm_pkg::STEPS][k].x);
            end
        end
    end

    // Stage 18: first level of products.
    logic signed [17:0] r_sxsy, r_sxcy, r_cysz, r_sysz, r_cxcz, r_cxsy, r_cxcy;
    logic signed [17:0] r_sx1, r_cz1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sxsy <= evm_pkg::mul14(r_s[0], r_s[1]);
            r_sxcy <= evm_pkg::mul14(r_s[0], r_c[1]);
            r_cysz <= evm_pkg::mul14(r_c[1], r_s[2]);
            r_sysz <= evm_pkg::mul14(r_s[1], r_s[2]);
            r_cxcz <= evm_pkg::mul14(r_c[0], r_c[2]);
            r_cxsy <= evm_pkg::mul14(r_c[0], r_s[1]);
            r_cxcy <= evm_pkg::mul14(r_c[0], r_c[1]);
            r_sx1 <= r_s[0];
            r_cz1 <= r_c[2];
        end
    end

    // Stage 19: up and front vectors.
    logic signed [17:0] r_u [2:0];
    logic signed [17:0] r_f [2:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u[0] <= 18'(evm_pkg::clamp_unit(48'(evm_pkg::mul14(r_sxsy, r_cz1))
                                              + 48'(r_cysz)));
            r_u[1] <= 18'(evm_pkg::clamp_unit(48'(r_cxcz)));
            r_u[2] <= 18'(evm_pkg::clamp_unit(48'(r_sysz)
                                              - 48'(evm_pkg::mul14(r_sxcy, r_cz1))));
            r_f[0] <= 18'(evm_pkg::clamp_unit(-48'(r_cxsy)));
            r_f[1] <= r_sx1;
            r_f[2] <= 18'(evm_pkg::clamp_unit(48'(r_cxcy)));
        end
    end

    // Stage 20: cross product partial terms.
    logic signed [35:0] r_pa [2:0];
    logic signed [35:0] r_pb [2:0];
    logic signed [17:0] r_u2 [2:0];
    logic signed [17:0] r_f2 [2:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa[0] <= r_f[1] * r_u[2];  r_pb[0] <= r_f[2] * r_u[1];
            r_pa[1] <= r_f[2] * r_u[0];  r_pb[1] <= r_f[0] * r_u[2];
            r_pa[2] <= r_f[0] * r_u[1];  r_pb[2] <= r_f[1] * r_u[0];
            r_u2 <= r_u;
            r_f2 <= r_f;
        end
    end

    // Stage 21: right vector.
    logic signed [17:0] r_r3 [2:0];
    logic signed [17:0] r_u3 [2:0];
    logic signed [17:0] r_f3 [2:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++)
                r_r3[k] <= 18'(evm_pkg::clamp_unit(
                    evm_pkg::rnd14(48'(r_pa[k]) - 48'(r_pb[k]))));
            r_u3 <= r_u2;
            r_f3 <= r_f2;
        end
    end

    // Stage 22: per-axis dot product terms, 18 by 32 bits.
    logic signed [49:0] r_t [2:0][2:0];
    logic signed [17:0] r_v4 [2:0][2:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_t[0][k] <= 50'(r_r3[k]) * 50'(k == 0 ? r_px[DEPTH-3] :
                                                k == 1 ? r_py[DEPTH-3] : r_pz[DEPTH-3]);
                r_t[1][k] <= 50'(r_u3[k]) * 50'(k == 0 ? r_px[DEPTH-3] :
                                                k == 1 ? r_py[DEPTH-3] : r_pz[DEPTH-3]);
                r_t[2][k] <= 50'(r_f3[k]) * 50'(k == 0 ? r_px[DEPTH-3] :
                                                k == 1 ? r_py[DEPTH-3] : r_pz[DEPTH-3]);
            end
            r_v4[0] <= r_r3;
            r_v4[1] <= r_u3;
            r_v4[2] <= r_f3;
        end
    end

    // Stage 23 output register: sum, sign, round and saturate.
    function automatic logic signed [31:0] offs(input logic signed [49:0] a,
                                               input logic signed [49:0] b,
                                               input logic signed [49:0] c,
                                               input logic neg);
        logic signed [51:0] d;
        logic signed [51:0] q;
        d = 52'(a) + 52'(b) + 52'(c);
        if (neg) d = -d;
        q = (d + 52'sd8192) >>> 14;
        if (q > 52'sd2147483647) return 32'sh7fffffff;
        if (q < -52'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_mat.right_x <= r_v4[0][0][15:0];
            o_mat.right_y <= r_v4[0][1][15:0];
            o_mat.right_z <= r_v4[0][2][15:0];
            o_mat.up_x <= r_v4[1][0][15:0];
            o_mat.up_y <= r_v4[1][1][15:0];
            o_mat.up_z <= r_v4[1][2][15:0];
            o_mat.back_x <= 16'(-r_v4[2][0]);
            o_mat.back_y <= 16'(-r_v4[2][1]);
            o_mat.back_z <= 16'(-r_v4[2][2]);
            o_mat.right_offset <= offs(r_t[0][0], r_t[0][1], r_t[0][2], 1'b1);
            o_mat.up_offset <= offs(r_t[1][0], r_t[1][1], r_t[1][2], 1'b1);
            o_mat.back_offset <= offs(r_t[2][0], r_t[2][1], r_t[2][2], 1'b0);
        end
    end

endmodule

[rtl/core/evm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_checker
// Port-level checks on the view matrix core, bound to the top level.
// ----------------------------------------------------------------------------
module evm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic signed [15:0] i_up_y,
    input logic signed [15:0] i_right_x
);

    // A held result stays valid and keeps its up_y field.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_up_y))
        else $error("held result changed");

    // Input is refused only while a result is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without back pressure");

    // The up_y and right_x entries stay within unit magnitude.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_up_y <= 16'sd16384 && i_up_y >= -16'sd16384
                         && i_right_x <= 16'sd16384 && i_right_x >= -16'sd16384))
        else $error("entry beyond unit range");

endmodule

bind euler_view_matrix_core evm_checker u_evm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_pose.ready),
    .i_out_valid(o_mat.valid), .i_out_ready(o_mat.ready),
    .i_up_y(o_mat.up_y), .i_right_x(o_mat.right_x)
);

[test/tb_euler_view_matrix_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_view_matrix_core
// Self-checking testbench for the Euler angle view matrix core.
// ----------------------------------------------------------------------------
// Camera poses are driven over the input channel with random gaps. The
// expected matrix rows are worked out in fixed point (range reduction,
// CORDIC, rounded products, saturated offsets) and compared field by field
// with each result transaction, in order. A long sink hold-off and a sender
// pause that drains the pipeline are exercised along the way.
// ----------------------------------------------------------------------------
module tb_euler_view_matrix_core;

    localparam int  TURN = 46080;
    localparam int  HALF = 23040;
    localparam int  QUARTER = 11520;
    localparam longint GAIN = 652032874;
    localparam int  N_RANDOM = 1700;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  LONG_HOLD = 200;

    typedef struct packed {
        logic signed [16:0] pitch;
        logic signed [16:0] yaw;
        logic signed [16:0] roll;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               pause;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] rx, ry, rz;
        logic signed [31:0] ro;
        logic signed [15:0] ux, uy, uz;
        logic signed [31:0] uo;
        logic signed [15:0] bx, by, bz;
        logic signed [31:0] bo;
    } rows_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    evm_in_if  pose_ch ();
    evm_out_if mat_ch ();

    euler_view_matrix_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_ch.sink),
        .o_mat   (mat_ch.source)
    );

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    pose_t  pending_poses[$];
    rows_t  expected_rows[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    bit     stimulus_done = 0;
    bit     quiet_tail = 0;
    bit     hold_request = 0;
    bit     hold_done = 0;
    bit     paused = 0;

    longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115};

    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shift(a * b, 14);
    endfunction

    // Sine and cosine of an angle in Q7 degrees, via range folding and CORDIC.
    function automatic void angle_trig(input longint a, output longint s,
                                       output longint c);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = a % TURN;
        flip = 0;
        if (r < 0) r += TURN;
        if (r >= HALF) r -= TURN;
        if (r > QUARTER) begin
            r = HALF - r;
            flip = 1;
        end else if (r < -QUARTER) begin
            r = -HALF - r;
            flip = 1;
        end
        x = GAIN;
        y = 0;
        z = r * 512;
        for (int i = 0; i < 16; i++) begin
            dx = fdiv(y, i);
            dy = fdiv(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = unit_clamp(round_shift(y, 16));
        c = unit_clamp(round_shift(x, 16));
        if (flip) c = -c;
    endfunction

    // Expected view matrix rows for one pose.
    function automatic rows_t view_rows(pose_t p);
        longint sx, cx, sy, cy, sz, cz;
        longint u0, u1, u2, f0, f1, f2, r0, r1, r2, d;
        longint px, py, pz;
        rows_t  m;
        angle_trig(longint'(p.pitch), sx, cx);
        angle_trig(-longint'(p.yaw), sy, cy);
        angle_trig(longint'(p.roll), sz, cz);
        px = longint'(p.px);
        py = longint'(p.py);
        pz = longint'(p.pz);
        u0 = unit_clamp(qmul(qmul(sx, sy), cz) + qmul(cy, sz));
        u1 = unit_clamp(qmul(cx, cz));
        u2 = unit_clamp(-qmul(qmul(sx, cy), cz) + qmul(sy, sz));
        f0 = unit_clamp(-qmul(cx, sy));
        f1 = sx;
        f2 = unit_clamp(qmul(cx, cy));
        r0 = unit_clamp(round_shift(f1 * u2 - f2 * u1, 14));
        r1 = unit_clamp(round_shift(f2 * u0 - f0 * u2, 14));
        r2 = unit_clamp(round_shift(f0 * u1 - f1 * u0, 14));
        m.rx = 16'(r0); m.ry = 16'(r1); m.rz = 16'(r2);
        d = r0 * px + r1 * py + r2 * pz;
        m.ro = 32'(sat_word(round_shift(-d, 14)));
        m.ux = 16'(u0); m.uy = 16'(u1); m.uz = 16'(u2);
        d = u0 * px + u1 * py + u2 * pz;
        m.uo = 32'(sat_word(round_shift(-d, 14)));
        m.bx = 16'(-f0); m.by = 16'(-f1); m.bz = 16'(-f2);
        d = f0 * px + f1 * py + f2 * pz;
        m.bo = 32'(sat_word(round_shift(d, 14)));
        return m;
    endfunction

    function automatic logic signed [16:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 17'(-46080 + $urandom_range(0, 3));
            1: return 17'(46080 - $urandom_range(0, 3));
            2: return 17'($urandom_range(0, 8) * 5760 - 23040 + $urandom_range(0, 2) - 1);
            default: return 17'(int'($urandom_range(0, 92160)) - 46080);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 2000000)) - 32'sd1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_t make_pose(int pi, int ya, int ro,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pose_t p;
        p.pitch = 17'(pi); p.yaw = 17'(ya); p.roll = 17'(ro);
        p.px = x; p.py = y; p.pz = z;
        p.pause = 0;
        return p;
    endfunction

    // Stimulus: directed corner poses, then random poses.
    initial begin
        pose_t p;
        int    corners[10] = '{0, 11520, -11520, 23040, -23040, 46080, -46080,
                               11521, -65536, 65535};
        for (int i = 0; i < 10; i++)
            pending_poses.push_back(make_pose(corners[i], corners[9 - i],
                                              corners[(i + 3) % 10],
                                              32'h7fffffff, 32'h80000000, 32'h00010000));
        pending_poses.push_back(make_pose(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_poses.push_back(make_pose(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
        pending_poses.push_back(make_pose(5760, -5760, 5760, 32'hffffffff, 0, 1));
        pending_poses.push_back(make_pose(-1, 1, -1, 32'h55555555, 32'haaaaaaaa, 0));
        pending_poses.push_back(make_pose(23039, -23041, 46079, 0, 32'h12345678, 32'hedcba987));
        for (int i = 0; i < N_RANDOM; i++) begin
            p.pitch = rand_angle(); p.yaw = rand_angle(); p.roll = rand_angle();
            p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
            p.pause = (i == 900);
            pending_poses.push_back(p);
        end
    end

    task automatic p_issue(pose_t p);
        expected_rows.push_back(view_rows(p));
        pose_ch.valid <= 1'b1;
        pose_ch.pitch_deg <= p.pitch; pose_ch.yaw_deg <= p.yaw; pose_ch.roll_deg <= p.roll;
        pose_ch.pos_x <= p.px; pose_ch.pos_y <= p.py; pose_ch.pos_z <= p.pz;
    endtask

    // Driver: offers pending poses with random idle bursts.
    int drive_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.valid <= 1'b0;
            pose_ch.pitch_deg <= '0; pose_ch.yaw_deg <= '0; pose_ch.roll_deg <= '0;
            pose_ch.pos_x <= '0; pose_ch.pos_y <= '0; pose_ch.pos_z <= '0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                n_sent++;
                if (n_sent == 200) hold_request = 1;
                if (n_sent > N_RANDOM - 100) quiet_tail = 1;
            end
            if (!pose_ch.valid || pose_ch.ready) begin
                if (paused && expected_rows.size() == 0) paused = 0;
                if (drive_gap > 0) drive_gap--;
                if (pending_poses.size() == 0 || paused || drive_gap > 0) begin
                    pose_ch.valid <= 1'b0;
                    if (pending_poses.size() == 0) stimulus_done = 1;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    drive_gap = $urandom_range(1, 5);
                    pose_ch.valid <= 1'b0;
                end else if (pending_poses[0].pause) begin
                    pending_poses[0].pause = 0;
                    paused = 1;
                    pose_ch.valid <= 1'b0;
                end else begin
                    p_issue(pending_poses.pop_front());
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest expectation.
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        rows_t want, got;
        if (!i_rst_n) begin
            mat_ch.ready <= 1'b0;
        end else begin
            if (mat_ch.valid && mat_ch.ready) begin
                got = '{mat_ch.right_x, mat_ch.right_y, mat_ch.right_z, mat_ch.right_offset,
                        mat_ch.up_x, mat_ch.up_y, mat_ch.up_z, mat_ch.up_offset,
                        mat_ch.back_x, mat_ch.back_y, mat_ch.back_z, mat_ch.back_offset};
                if (expected_rows.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction %h", $time, got);
                end else begin
                    want = expected_rows.pop_front();
                    n_checked++;
                    if (got != want) begin
                        errors++;
                        $display("%0t: matrix mismatch expected %h actual %h", $time, want, got);
                        $display("  right %0d %0d %0d %0d vs %0d %0d %0d %0d",
                                 want.rx, want.ry, want.rz, want.ro,
                                 got.rx, got.ry, got.rz, got.ro);
                        $display("  up %0d %0d %0d %0d vs %0d %0d %0d %0d",
                                 want.ux, want.uy, want.uz, want.uo,
                                 got.ux, got.uy, got.uz, got.uo);
                        $display("  back %0d %0d %0d %0d vs %0d %0d %0d %0d",
                                 want.bx, want.by, want.bz, want.bo,
                                 got.bx, got.by, got.bz, got.bo);
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                mat_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                mat_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 4);
                mat_ch.ready <= 1'b0;
            end else begin
                mat_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, watchdog and end of run.
    initial begin
        int idle_cycles;
        int tail;
        idle_cycles = 0;
        tail = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (tail < DRAIN_CYCLES && idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pose_ch.valid && pose_ch.ready) || (mat_ch.valid && mat_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stimulus_done && expected_rows.size() == 0) tail++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, expected_rows.size());
            $display("** euler_view_matrix_core: FAILED **");
        end else begin
            $display("Ran %0d poses (corner angles, wraps, saturating offsets) and checked %0d",
                     n_sent, n_checked);
            $display("matrices under random stalls, a long sink hold-off and a drain pause.");
            if (errors == 0)
                $display("** euler_view_matrix_core: PASSED **");
            else
                $display("** euler_view_matrix_core: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/evm_pkg.sv
rtl/core/evm_if.sv
rtl/core/evm_cordic_cell.sv
rtl/core/euler_view_matrix_core.sv
rtl/core/evm_checker.sv
test/tb_euler_view_matrix_core.sv
